[hdl/windowed_abs_sum_2d_assert.svh]
// Assertion macros for the checker file.
`ifndef WINDOWED_ABS_SUM_2D_ASSERT_SVH
`define WINDOWED_ABS_SUM_2D_ASSERT_SVH

// Clocked assertion, disabled while reset is held.
`define WASD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define WASD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hdl/wasd_pkg.sv]
package wasd_pkg;

  localparam int SampleW = 16;
  localparam int MagW    = 17;
  localparam int RowW    = 5;
  localparam int ColW    = 5;
  localparam int SumW    = 21;
  localparam int CfgW    = 6;
  localparam int OutW    = 32;

  localparam logic RegMatrixSize = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // Magnitude of a signed Q8.8 sample.
  function automatic logic [MagW-1:0] sample_mag(input logic [SampleW-1:0] raw);
    logic [MagW-1:0] neg;
    neg = 17'h10000 - {1'b0, raw};
    return raw[SampleW-1] ? neg : {1'b0, raw};
  endfunction

endpackage

[hdl/windowed_abs_sum_2d.sv]
// Flow: a sample that completes windows is followed, for each result, by READ (one store read
// per sample in the clipped window), DRAIN and EMIT, which loads the output register.
// The input is not ready again until every result of the sample has been emitted (up to 35
// results of up to 35 reads each); EMIT waits while the output register is full and not taken.
// Throughput is set by the single read port of the row store.
// Reset: asynchronous, active low; matrix_size returns to 32 and position to (0,0).
module windowed_abs_sum_2d #(
  parameter int MAX_SIZE = 32,
  parameter int WIN_ROWS = 7,
  parameter int WIN_COLS = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [4:0] out_row, [9:5] out_col, [30:10] window_sum
  output logic        m_axis_tlast    // last_of_matrix
);

  import wasd_pkg::*;

  localparam int NW    = $clog2(MAX_SIZE + 1);
  localparam int EW    = NW + 5;
  localparam int CW    = $clog2(MAX_SIZE);
  localparam int SW    = (WIN_ROWS > 1) ? $clog2(WIN_ROWS) : 1;
  localparam int AW    = SW + CW;
  localparam int Depth = WIN_ROWS << CW;
  localparam int AccW0 = MagW + $clog2(WIN_ROWS * WIN_COLS + 1);
  localparam int AccW  = (AccW0 > SumW) ? AccW0 : SumW;
  localparam logic [EW-1:0] WR = EW'(WIN_ROWS);
  localparam logic [EW-1:0] WC = EW'(WIN_COLS);
  localparam logic [SW-1:0] SlotLast = SW'(WIN_ROWS - 1);

  state_e state_q, state_d;

  logic [CfgW-1:0] ms_q;
  logic [NW-1:0]   row_q, col_q;
  logic [SW-1:0]   slot_q;
  logic [NW-1:0]   r_q, r_d, c_q, c_d, k_q, k_d, m_q, m_d;
  logic [NW-1:0]   clo_q, clo_d, chi_q, chi_d, rhi_q, rhi_d;
  logic [SW-1:0]   rslot_q, rslot_d, kslot_q, kslot_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            rdv_q;
  logic            out_vld_q;
  logic [RowW-1:0] out_row_q;
  logic [ColW-1:0] out_col_q;
  logic [SumW-1:0] out_sum_q;
  logic            out_last_q;

  logic            cfg_wr, in_xfer, out_load, out_free;
  logic [NW-1:0]   n;
  logic [EW-1:0]   n_e, row_e, col_e;
  logic            rlast, clast, rok, cok;
  logic [NW-1:0]   rlo, clo, rhi, chi;
  logic [SW-1:0]   slot_nx, rslot_lo;
  logic [EW-1:0]   rend_e, cend_e;
  logic            m_last, k_last;
  logic [SampleW-1:0] rdata;

  // Effective matrix size: zero acts as one, clamp to the store size.
  always_comb begin
    if (ms_q == '0) begin
      n = NW'(1);
    end else if (EW'(ms_q) > EW'(MAX_SIZE)) begin
      n = NW'(MAX_SIZE);
    end else begin
      n = NW'(ms_q);
    end
  end

  assign n_e   = EW'(n);
  assign row_e = EW'(row_q);
  assign col_e = EW'(col_q);

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMatrixSize) ? {{(32 - CfgW){1'b0}}, ms_q} : '0;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegMatrixSize);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;

  // Window corners completed by the incoming sample.
  always_comb begin
    rlast = (row_e == n_e - EW'(1));
    clast = (col_e == n_e - EW'(1));
    rok   = rlast || (row_e >= WR - EW'(1));
    cok   = clast || (col_e >= WC - EW'(1));
    if (rlast) begin
      rlo = (n_e >= WR) ? NW'(n_e - WR) : '0;
      rhi = n - NW'(1);
    end else begin
      rlo = NW'(row_e - (WR - EW'(1)));
      rhi = rlo;
    end
    if (clast) begin
      clo = (n_e >= WC) ? NW'(n_e - WC) : '0;
      chi = n - NW'(1);
    end else begin
      clo = NW'(col_e - (WC - EW'(1)));
      chi = clo;
    end
    slot_nx  = (slot_q == SlotLast) ? '0 : slot_q + SW'(1);
    rslot_lo = (rlast && n_e < WR) ? '0 : slot_nx;
  end

  // Clipped window end for the current corner.
  always_comb begin
    rend_e = EW'(r_q) + WR - EW'(1);
    if (rend_e > n_e - EW'(1)) begin
      rend_e = n_e - EW'(1);
    end
    cend_e = EW'(c_q) + WC - EW'(1);
    if (cend_e > n_e - EW'(1)) begin
      cend_e = n_e - EW'(1);
    end
    m_last = (EW'(m_q) == cend_e);
    k_last = (EW'(k_q) == rend_e);
  end

  assign out_load = (state_q == ST_EMIT) && out_free;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && rok && cok) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (m_last && k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = (c_q == chi_q && r_q == rhi_q) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Walk corners and window samples.
  always_comb begin
    r_d = r_q;  c_d = c_q;  k_d = k_q;  m_d = m_q;
    clo_d = clo_q;  chi_d = chi_q;  rhi_d = rhi_q;
    rslot_d = rslot_q;  kslot_d = kslot_q;
    acc_d = acc_q;
    if (rdv_q) begin
      acc_d = acc_q + AccW'(sample_mag(rdata));
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          r_d = rlo;  c_d = clo;  k_d = rlo;  m_d = clo;
          clo_d = clo;  chi_d = chi;  rhi_d = rhi;
          rslot_d = rslot_lo;  kslot_d = rslot_lo;
          acc_d = '0;
        end
      end
      ST_READ: begin
        if (m_last) begin
          m_d = c_q;
          if (!k_last) begin
            k_d = k_q + NW'(1);
            kslot_d = (kslot_q == SlotLast) ? '0 : kslot_q + SW'(1);
          end
        end else begin
          m_d = m_q + NW'(1);
        end
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        if (out_free) begin
          acc_d = '0;
          if (c_q == chi_q) begin
            c_d = clo_q;
            m_d = clo_q;
            r_d = r_q + NW'(1);
            k_d = r_q + NW'(1);
            rslot_d = (rslot_q == SlotLast) ? '0 : rslot_q + SW'(1);
            kslot_d = (rslot_q == SlotLast) ? '0 : rslot_q + SW'(1);
          end else begin
            c_d = c_q + NW'(1);
            m_d = c_q + NW'(1);
            k_d = r_q;
            kslot_d = rslot_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ms_q      <= CfgW'(32);
      row_q     <= '0;
      col_q     <= '0;
      slot_q    <= '0;
      rdv_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rdv_q   <= (state_q == ST_READ);
      if (cfg_wr) begin
        ms_q   <= pwdata[CfgW-1:0];
        row_q  <= '0;
        col_q  <= '0;
        slot_q <= '0;
      end else if (in_xfer) begin
        if (col_q == n - NW'(1)) begin
          col_q <= '0;
          if (row_q == n - NW'(1)) begin
            row_q  <= '0;
            slot_q <= '0;
          end else begin
            row_q  <= row_q + NW'(1);
            slot_q <= slot_nx;
          end
        end else begin
          col_q <= col_q + NW'(1);
        end
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    r_q <= r_d;  c_q <= c_d;  k_q <= k_d;  m_q <= m_d;
    clo_q <= clo_d;  chi_q <= chi_d;  rhi_q <= rhi_d;
    rslot_q <= rslot_d;  kslot_q <= kslot_d;
    acc_q <= acc_d;
    if (out_load) begin
      out_row_q  <= RowW'(r_q);
      out_col_q  <= ColW'(c_q);
      out_sum_q  <= acc_q[SumW-1:0];
      out_last_q <= (r_q == n - NW'(1)) && (c_q == n - NW'(1));
    end
  end

  wasd_ram #(
    .Depth (Depth),
    .AddrW (AW),
    .DataW (SampleW)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (in_xfer),
    .waddr_i ({slot_q, col_q[CW-1:0]}),
    .wdata_i (s_axis_tdata),
    .re_i    (state_q == ST_READ),
    .raddr_i ({kslot_q, m_q[CW-1:0]}),
    .rdata_o (rdata)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_sum_q, out_col_q, out_row_q};
  assign m_axis_tlast  = out_last_q;

endmodule

[hdl/wasd_ram.sv]
module wasd_ram #(
  parameter int Depth = 224,
  parameter int AddrW = 8,
  parameter int DataW = 16
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [0:Depth-1];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[hdl/wasd_checker.sv]
module wasd_checker #(
  parameter int WIN_ROWS = 7,
  parameter int WIN_COLS = 5
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  `include "windowed_abs_sum_2d_assert.svh"

  localparam logic [31:0] SumMax = 32'(WIN_ROWS * WIN_COLS * 32768);

  // Hold a stalled result.
  `WASD_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")

  // The last result sits on the diagonal corner.
  `WASD_ASSERT(a_last_diag, m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[4:0] == m_axis_tdata[9:5], "last result off diagonal")

  // Window sums stay within the window bound.
  `WASD_ASSERT(a_sum_bound, m_axis_tvalid |-> {11'b0, m_axis_tdata[30:10]} <= SumMax, "window sum out of range")

  // The configuration port never stalls.
  `WASD_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind windowed_abs_sum_2d wasd_checker #(
  .WIN_ROWS (WIN_ROWS),
  .WIN_COLS (WIN_COLS)
) u_wasd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

[verif/tb_windowed_abs_sum_2d.sv]
module tb_windowed_abs_sum_2d;
  import wasd_pkg::*;

  localparam int MaxN = 32;
  localparam int WinR = 7;
  localparam int WinC = 5;
  localparam int StallLimit = 20000;
  localparam int DirN = 20;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [SumW-1:0] wsum;
    logic            last;
  } window_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        s_axis_tvalid, s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  windowed_abs_sum_2d uut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  // Predictor state: mirror of the row store, position and size
  logic [SampleW-1:0] sample_rows [WinR][MaxN];
  int unsigned        size_reg;
  int unsigned        pos_row, pos_col;
  window_res_t        sums_due [$];

  int errors;
  int results_seen;
  int samples_sent;
  int idle_cycles;
  bit hold_results;
  bit sink_long_hold;

  // Directed stimulus: value and expected sum (or -1)
  typedef struct {
    logic [15:0] value;
    int          sum_exp;
  } dir_row_t;
  dir_row_t dir_tab [DirN];

  always begin
    clk_i = 1'b0; #2;
    clk_i = 1'b1; #2;
  end

  function automatic int unsigned eff_size();
    if (size_reg == 0) return 1;
    if (size_reg > MaxN) return MaxN;
    return size_reg;
  endfunction

  function automatic int unsigned abs_q88(logic [15:0] raw);
    return raw[15] ? (32'h10000 - raw) : raw;
  endfunction

  // Push every window completed by this sample, in row then column order
  task automatic predict_windows(input logic [15:0] value);
    int n, i, j, rlo, rhi, clo, chi, rend, cend;
    int unsigned acc;
    window_res_t res;
    n = eff_size();
    if (pos_row >= n || pos_col >= n) begin
      pos_row = 0;
      pos_col = 0;
    end
    i = pos_row;
    j = pos_col;
    sample_rows[i % WinR][j] = value;
    rlo = -1;
    clo = -1;
    if (i == n - 1) begin
      rlo = (n - WinR < 0) ? 0 : n - WinR;
      rhi = n - 1;
    end else if (i >= WinR - 1) begin
      rlo = i - (WinR - 1);
      rhi = rlo;
    end
    if (j == n - 1) begin
      clo = (n - WinC < 0) ? 0 : n - WinC;
      chi = n - 1;
    end else if (j >= WinC - 1) begin
      clo = j - (WinC - 1);
      chi = clo;
    end
    if (rlo >= 0 && clo >= 0) begin
      for (int r = rlo; r <= rhi; r++) begin
        for (int c = clo; c <= chi; c++) begin
          acc = 0;
          rend = (r + WinR - 1 > n - 1) ? n - 1 : r + WinR - 1;
          cend = (c + WinC - 1 > n - 1) ? n - 1 : c + WinC - 1;
          for (int k = r; k <= rend; k++)
            for (int m = c; m <= cend; m++)
              acc += abs_q88(sample_rows[k % WinR][m]);
          res.row  = r[RowW-1:0];
          res.col  = c[ColW-1:0];
          res.wsum = acc[SumW-1:0];
          res.last = (r == n - 1 && c == n - 1);
          sums_due.push_back(res);
        end
      end
    end
    pos_col++;
    if (pos_col >= n) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= n) pos_row = 0;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Drop valid for a random gap; no gap keeps the stream going
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Send one sample and predict its windows at the accepting edge
  task automatic send_sample(input logic [15:0] value, input bit gaps);
    if (gaps) idle_gap();
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_windows(value);
    samples_sent++;
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sums_due.size() != 0) @(posedge clk_i);
    // items that complete no window may still be in flight
    repeat (1300) @(posedge clk_i);
  endtask

  task automatic write_size(input int unsigned value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegMatrixSize, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    size_reg = value & 6'h3f;
    pos_row  = 0;
    pos_col  = 0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  // Check each result against the oldest expected window
  always @(posedge clk_i) begin
    window_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (sums_due.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata, 0);
      end else begin
        want = sums_due.pop_front();
        if (m_axis_tdata[4:0] !== want.row) report_mismatch("row", m_axis_tdata[4:0], want.row);
        if (m_axis_tdata[9:5] !== want.col) report_mismatch("col", m_axis_tdata[9:5], want.col);
        if (m_axis_tdata[30:10] !== want.wsum)
          report_mismatch("sum", m_axis_tdata[30:10], want.wsum);
        if (m_axis_tlast !== want.last) report_mismatch("last", m_axis_tlast, want.last);
      end
    end
  end

  // Result sink: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_results) begin
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    hold_results = 1'b0;
    wait (sink_long_hold);
    hold_results = 1'b1;
    repeat (400) @(posedge clk_i);
    hold_results = 1'b0;
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int sizes [6];
    logic [15:0] v;
    errors = 0;
    results_seen = 0;
    samples_sent = 0;
    sink_long_hold = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    size_reg = 32;
    pos_row = 0;
    pos_col = 0;
    for (int r = 0; r < WinR; r++)
      for (int c = 0; c < MaxN; c++) sample_rows[r][c] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: size one (each sample is its own window), then size zero acting as one, then size three
    dir_tab[0] = '{16'h0000, 0};
    dir_tab[1] = '{16'h7fff, 32767};
    dir_tab[2] = '{16'h8000, 32768};
    dir_tab[3] = '{16'hffff, 1};
    dir_tab[4] = '{16'h0100, 256};
    for (int k = 5; k < DirN; k++) dir_tab[k] = '{rand_sample(), -1};
    write_size(1);
    for (int k = 0; k < DirN; k++) begin
      if (k == 5) write_size(0);
      if (k == 8) write_size(3);     // small matrix: all windows on the last sample
      if (dir_tab[k].sum_exp >= 0 && abs_q88(dir_tab[k].value) != dir_tab[k].sum_exp)
        report_mismatch("directed table", abs_q88(dir_tab[k].value), dir_tab[k].sum_exp);
      send_sample(dir_tab[k].value, 1'b1);
    end

    // Oversize setting acts as the maximum
    write_size(63);
    for (int k = 0; k < 12; k++) send_sample(rand_sample(), k > 6);
    drain_results();

    // Random phases over several sizes; one long receiver hold-off on the 7x7 matrix
    sizes = '{4, 5, 3, 7, 2, 32};
    foreach (sizes[s]) begin
      write_size(sizes[s]);
      if (sizes[s] == 7) sink_long_hold = 1'b1;
      for (int k = 0; k < ((s == 5) ? 20 : sizes[s] * sizes[s] + 3); k++) begin
        v = rand_sample();
        send_sample(v, 1'b1);
      end
      drain_results();   // sender waits until every result is in
    end

    repeat (50) @(posedge clk_i);
    $display("Covered %0d samples and %0d window results over sizes 0..63,",
             samples_sent, results_seen);
    $display("including clipped small matrices, wraparound and receiver back-pressure.");
    if (errors == 0 && sums_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
